// File: rtl/core/pcgbr_pkg.sv
// Package with the constants and types of the bounded PCG random generator.
package pcgbr_pkg;

  localparam logic [63:0] PcgMult = 64'd6364136223846793005;
  localparam logic [63:0] PcgInc = 64'd55;

  typedef enum logic [1:0] {
    REQ_RAW32 = 2'd0,
    REQ_BND32 = 2'd1,
    REQ_RAW64 = 2'd2,
    REQ_BND64 = 2'd3
  } req_type_e;

  typedef enum logic [9:0] {
    ST_IDLE  = 10'b0000000001,
    ST_PREP  = 10'b0000000010,
    ST_DIVQ  = 10'b0000000100,
    ST_LIM   = 10'b0000001000,
    ST_DRAW  = 10'b0000010000,
    ST_WAITD = 10'b0000100000,
    ST_CHECK = 10'b0001000000,
    ST_DIVX  = 10'b0010000000,
    ST_ADD   = 10'b0100000000,
    ST_OUT   = 10'b1000000000
  } state_e;

  typedef struct packed {
    logic       start;
    logic       seed_load;
    logic [63:0] seed;
  } gen_ctrl_t;

endpackage

// File: rtl/core/pcgbr_req_if.sv
// Valid-ready channel interfaces for requests and results.
interface pcgbr_req_if;
  logic        valid;
  logic        ready;
  logic [1:0]  req_type;
  logic [63:0] range_low;
  logic [63:0] range_high;
  modport source (output valid, req_type, range_low, range_high, input ready);
  modport sink (input valid, req_type, range_low, range_high, output ready);
endinterface

interface pcgbr_rsp_if;
  logic        valid;
  logic        ready;
  logic [63:0] rand_value;
  logic        range_error;
  modport source (output valid, rand_value, range_error, input ready);
  modport sink (input valid, rand_value, range_error, output ready);
endinterface

// File: rtl/core/pcgbr_serial_mul.sv
// Bit-serial 64x64 multiplier keeping the low 64 bits, plus an addend.
module pcgbr_serial_mul (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  input  logic [63:0] a_i,
  input  logic [63:0] b_i,
  input  logic [63:0] c_i,
  output logic        busy_o,
  output logic        done_o,
  output logic [63:0] p_o
);
  logic [63:0] acc_q, acc_d, a_q, a_d, b_q, b_d;
  logic [6:0]  cnt_q, cnt_d;
  logic        busy_q, busy_d, done_q, done_d;

  always_comb begin
    acc_d = acc_q;
    a_d = a_q;
    b_d = b_q;
    cnt_d = cnt_q;
    busy_d = busy_q;
    done_d = 1'b0;
    if (start_i) begin
      acc_d = c_i;
      a_d = a_i;
      b_d = b_i;
      cnt_d = 7'd0;
      busy_d = 1'b1;
    end else if (busy_q) begin
      if (b_q[0]) begin
        acc_d = acc_q + a_q;
      end
      a_d = {a_q[62:0], 1'b0};
      b_d = {1'b0, b_q[63:1]};
      cnt_d = cnt_q + 7'd1;
      if (cnt_q == 7'd63) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q <= 7'd0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    acc_q <= acc_d;
    a_q <= a_d;
    b_q <= b_d;
  end

  assign busy_o = busy_q;
  assign done_o = done_q;
  assign p_o = acc_q;
endmodule

// File: rtl/core/pcgbr_serial_div.sv
// Bit-serial restoring 64-bit unsigned divider.
module pcgbr_serial_div (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  input  logic [63:0] num_i,
  input  logic [63:0] den_i,
  output logic        done_o,
  output logic [63:0] quo_o
);
  logic [63:0] quo_q, quo_d, den_q, den_d;
  logic [63:0] rem_q, rem_d;
  logic [64:0] trial;
  logic [6:0]  cnt_q, cnt_d;
  logic        busy_q, busy_d, done_q, done_d;

  always_comb begin
    quo_d = quo_q;
    den_d = den_q;
    rem_d = rem_q;
    cnt_d = cnt_q;
    busy_d = busy_q;
    done_d = 1'b0;
    trial = {rem_q, quo_q[63]} - {1'b0, den_q};
    if (start_i) begin
      quo_d = num_i;
      den_d = den_i;
      rem_d = '0;
      cnt_d = 7'd0;
      busy_d = 1'b1;
    end else if (busy_q) begin
      if (trial[64]) begin
        rem_d = {rem_q[62:0], quo_q[63]};
        quo_d = {quo_q[62:0], 1'b0};
      end else begin
        rem_d = trial[63:0];
        quo_d = {quo_q[62:0], 1'b1};
      end
      cnt_d = cnt_q + 7'd1;
      if (cnt_q == 7'd63) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q <= 7'd0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    quo_q <= quo_d;
    den_q <= den_d;
    rem_q <= rem_d;
  end

  assign done_o = done_q;
  assign quo_o = quo_q;
endmodule

// File: rtl/core/pcgbr_gen.sv
// PCG state register with serial LCG advance and XSH-RR output permutation.
module pcgbr_gen (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  pcgbr_pkg::gen_ctrl_t ctrl_i,
  output logic                 done_o,
  output logic [31:0]          word_o
);
  logic [63:0] state_q, state_d, mul_p, mul_a;
  logic        mul_start, mul_busy, mul_done, pend_q, pend_d;
  logic [31:0] xs;
  logic [4:0]  rot;

  assign mul_start = ctrl_i.start | ctrl_i.seed_load;
  assign mul_a = ctrl_i.seed_load ? ctrl_i.seed : (mul_done ? mul_p : state_q);

  pcgbr_serial_mul u_mul (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(mul_start),
    .a_i    (mul_a),
    .b_i    (pcgbr_pkg::PcgMult),
    .c_i    (pcgbr_pkg::PcgInc),
    .busy_o (mul_busy),
    .done_o (mul_done),
    .p_o    (mul_p)
  );

  always_comb begin
    state_d = state_q;
    pend_d = pend_q;
    if (mul_done) begin
      state_d = mul_p;
      pend_d = 1'b0;
    end
    if (ctrl_i.start) begin
      pend_d = 1'b1;
    end else if (ctrl_i.seed_load) begin
      pend_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= pcgbr_pkg::PcgInc;
      pend_q <= 1'b0;
    end else begin
      state_q <= state_d;
      pend_q <= pend_d;
    end
  end

  assign xs = 32'(((mul_p >> 18) ^ mul_p) >> 27);
  assign rot = mul_p[63:59];
  assign word_o = (xs >> rot) | (xs << ((5'd0 - rot) & 5'd31));
  assign done_o = mul_done & pend_q & ~mul_busy;
endmodule

// File: rtl/core/pcg_bounded_random_generator.sv
// Top level of the bounded PCG random generator.
// Requests arrive on req (req_type, range_low, range_high) as valid-ready
// beats; each request yields exactly one result beat on rsp (rand_value,
// range_error). One request is handled at a time.
// Each 32-bit draw advances the 64-bit LCG state through a bit-serial
// multiplier; a 64-bit draw takes two such 32-bit draws.
// Bounded draws first compute the quotient with a bit-serial divider,
// the rejection limit with a second bit-serial multiplier, then draw
// until accepted, divide once more and add the lower bound.
// Equal or reversed bounds finish without a draw; full-range bounds draw raw.
// The seed register is written through seed_we_i / seed_value_i; a write
// loads the state and advances it once.
// After reset the state is 55 (the zero seed advanced once) and the block is
// idle. When the receiver stalls, the result beat holds and no new request
// is taken until it is delivered.
module pcg_bounded_random_generator (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          seed_we_i,
  input  logic [63:0]   seed_value_i,
  pcgbr_req_if.sink     req,
  pcgbr_rsp_if.source   rsp
);
  pcgbr_pkg::state_e   st_q, st_d;
  pcgbr_pkg::gen_ctrl_t gctl;
  logic [1:0]  kind_q, kind_d;
  logic [63:0] low_q, low_d, high_q, high_d, q_q, q_d, lim_q, lim_d;
  logic [63:0] x_q, x_d, val_q, val_d, rng;
  logic        err_q, err_d, half_q, half_d, full_q, full_d;
  logic        gen_done, mul_start, mul_done, mul_busy, div_start, div_done;
  logic [63:0] mul_p, div_q, div_num, div_den;
  logic [31:0] word;
  logic        is32;

  assign is32 = kind_q inside {pcgbr_pkg::REQ_RAW32, pcgbr_pkg::REQ_BND32};
  assign rng = high_q - low_q + 64'd1;

  pcgbr_gen u_gen (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .ctrl_i(gctl),
    .done_o(gen_done),
    .word_o(word)
  );

  pcgbr_serial_mul u_lim (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(mul_start),
    .a_i    (rng),
    .b_i    (q_q),
    .c_i    (64'd0),
    .busy_o (mul_busy),
    .done_o (mul_done),
    .p_o    (mul_p)
  );

  assign div_num = (st_q == pcgbr_pkg::ST_PREP) ?
                   (is32 ? 64'h0000_0000_FFFF_FFFF : 64'hFFFF_FFFF_FFFF_FFFF) : x_q;
  assign div_den = (st_q == pcgbr_pkg::ST_PREP) ? rng : q_q;

  pcgbr_serial_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(div_start),
    .num_i  (div_num),
    .den_i  (div_den),
    .done_o (div_done),
    .quo_o  (div_q)
  );

  always_comb begin
    st_d = st_q;
    kind_d = kind_q;
    low_d = low_q;
    high_d = high_q;
    q_d = q_q;
    lim_d = lim_q;
    x_d = x_q;
    val_d = val_q;
    err_d = err_q;
    half_d = half_q;
    full_d = full_q;
    gctl.seed_load = seed_we_i;
    gctl.seed = seed_value_i;
    gctl.start = 1'b0;
    mul_start = 1'b0;
    div_start = 1'b0;
    case (st_q)
      pcgbr_pkg::ST_IDLE: begin
        if (req.valid) begin
          kind_d = req.req_type;
          err_d = 1'b0;
          half_d = 1'b0;
          full_d = 1'b0;
          if (req.req_type == pcgbr_pkg::REQ_BND32) begin
            low_d = {32'd0, req.range_low[31:0]};
            high_d = {32'd0, req.range_high[31:0]};
          end else begin
            low_d = req.range_low;
            high_d = req.range_high;
          end
          if (req.req_type inside {pcgbr_pkg::REQ_RAW32, pcgbr_pkg::REQ_RAW64}) begin
            full_d = 1'b1;
            st_d = pcgbr_pkg::ST_DRAW;
          end else begin
            st_d = pcgbr_pkg::ST_PREP;
          end
        end
      end
      pcgbr_pkg::ST_PREP: begin
        if (high_q < low_q) begin
          err_d = 1'b1;
          val_d = low_q;
          st_d = pcgbr_pkg::ST_OUT;
        end else if (high_q == low_q) begin
          val_d = low_q;
          st_d = pcgbr_pkg::ST_OUT;
        end else if (low_q == 64'd0 && (is32 ? high_q == 64'h0000_0000_FFFF_FFFF
                                             : high_q == 64'hFFFF_FFFF_FFFF_FFFF)) begin
          full_d = 1'b1;
          st_d = pcgbr_pkg::ST_DRAW;
        end else begin
          div_start = 1'b1;
          st_d = pcgbr_pkg::ST_DIVQ;
        end
      end
      pcgbr_pkg::ST_DIVQ: begin
        if (div_done) begin
          q_d = div_q;
          st_d = pcgbr_pkg::ST_LIM;
        end
      end
      pcgbr_pkg::ST_LIM: begin
        if (!mul_busy && !mul_done) begin
          mul_start = 1'b1;
        end
        if (mul_done) begin
          lim_d = mul_p;
          st_d = pcgbr_pkg::ST_DRAW;
        end
      end
      pcgbr_pkg::ST_DRAW: begin
        gctl.start = 1'b1;
        half_d = 1'b0;
        st_d = pcgbr_pkg::ST_WAITD;
      end
      pcgbr_pkg::ST_WAITD: begin
        if (gen_done) begin
          if (is32) begin
            x_d = {32'd0, word};
            st_d = pcgbr_pkg::ST_CHECK;
          end else if (!half_q) begin
            x_d = {word, 32'd0};
            half_d = 1'b1;
            gctl.start = 1'b1;
          end else begin
            x_d = {x_q[63:32], word};
            st_d = pcgbr_pkg::ST_CHECK;
          end
        end
      end
      pcgbr_pkg::ST_CHECK: begin
        if (full_q) begin
          val_d = x_q;
          st_d = pcgbr_pkg::ST_OUT;
        end else if (x_q >= lim_q) begin
          st_d = pcgbr_pkg::ST_DRAW;
        end else begin
          div_start = 1'b1;
          st_d = pcgbr_pkg::ST_DIVX;
        end
      end
      pcgbr_pkg::ST_DIVX: begin
        if (div_done) begin
          x_d = div_q;
          st_d = pcgbr_pkg::ST_ADD;
        end
      end
      pcgbr_pkg::ST_ADD: begin
        val_d = is32 ? {32'd0, x_q[31:0] + low_q[31:0]} : x_q + low_q;
        st_d = pcgbr_pkg::ST_OUT;
      end
      pcgbr_pkg::ST_OUT: begin
        if (rsp.ready) begin
          st_d = pcgbr_pkg::ST_IDLE;
        end
      end
      default: st_d = pcgbr_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= pcgbr_pkg::ST_IDLE;
      half_q <= 1'b0;
      full_q <= 1'b0;
      err_q <= 1'b0;
      kind_q <= pcgbr_pkg::REQ_RAW32;
    end else begin
      st_q <= st_d;
      half_q <= half_d;
      full_q <= full_d;
      err_q <= err_d;
      kind_q <= kind_d;
    end
  end

  always_ff @(posedge clk_i) begin
    low_q <= low_d;
    high_q <= high_d;
    q_q <= q_d;
    lim_q <= lim_d;
    x_q <= x_d;
    val_q <= val_d;
  end

  assign req.ready = (st_q == pcgbr_pkg::ST_IDLE);
  assign rsp.valid = (st_q == pcgbr_pkg::ST_OUT);
  assign rsp.rand_value = val_q;
  assign rsp.range_error = err_q;
endmodule

// File: sim/tb.sv
// Self-checking testbench for the bounded PCG random generator.
`timescale 1ns / 100ps

module tb;

  localparam int unsigned CycleLimit = 4000000;
  localparam int unsigned SeedSettle = 100;
  localparam int unsigned RandomItems = 1650;

  typedef struct {
    logic [63:0] value;
    logic        err;
  } draw_result_t;

  logic clk_i;
  logic rst_ni;
  logic seed_we_i;
  logic [63:0] seed_value_i;

  pcgbr_req_if req_ch ();
  pcgbr_rsp_if rsp_ch ();

  pcg_bounded_random_generator dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .seed_we_i    (seed_we_i),
    .seed_value_i (seed_value_i),
    .req          (req_ch),
    .rsp          (rsp_ch)
  );

  logic [63:0] gen_state;
  draw_result_t pending_draws[$];
  int unsigned mismatch_count = 0;
  int unsigned cycle_count = 0;
  int unsigned burst_left = 0;
  int unsigned hold_off_cycles = 0;
  int unsigned stall_window = 0;
  int unsigned stall_mode = 0;

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  function automatic logic [31:0] xsh_rr(logic [63:0] s);
    logic [31:0] xs;
    logic [4:0]  rot;
    xs  = 32'(((s >> 18) ^ s) >> 27);
    rot = s[63:59];
    return (xs >> rot) | (xs << ((32 - rot) & 31));
  endfunction

  function automatic logic [31:0] next_word();
    gen_state = gen_state * pcgbr_pkg::PcgMult + pcgbr_pkg::PcgInc;
    return xsh_rr(gen_state);
  endfunction

  function automatic logic [63:0] next_dword();
    logic [31:0] hi;
    hi = next_word();
    return {hi, next_word()};
  endfunction

  function automatic draw_result_t predict_draw(pcgbr_pkg::req_type_e kind,
                                                logic [63:0] lo, logic [63:0] hi);
    draw_result_t r;
    logic [31:0] lo32, hi32, span32, q32, lim32, x32;
    logic [63:0] span, q, lim, x;
    r.err = 1'b0;
    r.value = '0;
    lo32 = lo[31:0];
    hi32 = hi[31:0];
    case (kind)
      pcgbr_pkg::REQ_RAW32: r.value = {32'd0, next_word()};
      pcgbr_pkg::REQ_RAW64: r.value = next_dword();
      pcgbr_pkg::REQ_BND32: begin
        if (hi32 < lo32) begin
          r.err = 1'b1;
          r.value = {32'd0, lo32};
        end else if (hi32 == lo32) begin
          r.value = {32'd0, lo32};
        end else begin
          span32 = hi32 - lo32 + 32'd1;
          if (span32 == 0) begin
            r.value = {32'd0, next_word()};
          end else begin
            q32 = 32'hFFFF_FFFF / span32;
            lim32 = span32 * q32;
            x32 = next_word();
            while (x32 >= lim32) x32 = next_word();
            r.value = {32'd0, 32'(x32 / q32 + lo32)};
          end
        end
      end
      default: begin
        if (hi < lo) begin
          r.err = 1'b1;
          r.value = lo;
        end else if (hi == lo) begin
          r.value = lo;
        end else begin
          span = hi - lo + 64'd1;
          if (span == 0) begin
            r.value = next_dword();
          end else begin
            q = 64'hFFFF_FFFF_FFFF_FFFF / span;
            lim = span * q;
            x = next_dword();
            while (x >= lim) x = next_dword();
            r.value = x / q + lo;
          end
        end
      end
    endcase
    return r;
  endfunction

  task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
    $display("MISMATCH %s: got %h expected %h at cycle %0d", what, got, want, cycle_count);
    mismatch_count++;
  endtask

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CycleLimit) begin
      $display("*** FAILED ***");
      $finish;
    end
  end

  always @(negedge clk_i) begin
    if (hold_off_cycles > 0) begin
      hold_off_cycles <= hold_off_cycles - 1;
      rsp_ch.ready <= 1'b0;
    end else begin
      if (stall_window == 0) begin
        stall_window = $urandom_range(16, 128);
        stall_mode = $urandom_range(0, 3);
      end else begin
        stall_window--;
      end
      rsp_ch.ready <= (stall_mode == 0) ? 1'b1 : ($urandom_range(0, 3) >= stall_mode);
    end
  end

  always @(posedge clk_i) begin
    draw_result_t want;
    if (rst_ni && rsp_ch.valid && rsp_ch.ready) begin
      if (pending_draws.size() == 0) begin
        report_mismatch("unexpected beat", rsp_ch.rand_value, '0);
      end else begin
        want = pending_draws.pop_front();
        if (rsp_ch.rand_value !== want.value)
          report_mismatch("rand_value", rsp_ch.rand_value, want.value);
        if (rsp_ch.range_error !== want.err)
          report_mismatch("range_error", {63'd0, rsp_ch.range_error}, {63'd0, want.err});
      end
    end
  end

  // Entered and left at a falling edge.
  task automatic send_request(pcgbr_pkg::req_type_e kind, logic [63:0] lo, logic [63:0] hi);
    if (burst_left == 0) begin
      req_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 20)) @(negedge clk_i);
      burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(50, 200)
                                                : $urandom_range(1, 30);
    end
    burst_left--;
    req_ch.valid <= 1'b1;
    req_ch.req_type <= kind;
    req_ch.range_low <= lo;
    req_ch.range_high <= hi;
    forever begin
      @(posedge clk_i);
      if (req_ch.ready) break;
    end
    pending_draws.push_back(predict_draw(kind, lo, hi));
    @(negedge clk_i);
  endtask

  task automatic drain();
    req_ch.valid <= 1'b0;
    burst_left = 0;
    while (pending_draws.size() != 0) @(negedge clk_i);
    repeat (SeedSettle) @(negedge clk_i);
  endtask

  task automatic write_seed(logic [63:0] seed);
    drain();
    seed_we_i <= 1'b1;
    seed_value_i <= seed;
    @(negedge clk_i);
    seed_we_i <= 1'b0;
    gen_state = seed * pcgbr_pkg::PcgMult + pcgbr_pkg::PcgInc;
    repeat (SeedSettle) @(negedge clk_i);
  endtask

  task automatic test_reset_state();
    send_request(pcgbr_pkg::REQ_RAW32, '0, '0);
    send_request(pcgbr_pkg::REQ_RAW64, '1, '1);
    send_request(pcgbr_pkg::REQ_RAW32, '1, '0);
  endtask

  task automatic test_directed();
    write_seed(64'd0);
    send_request(pcgbr_pkg::REQ_BND32, 64'd7, 64'd7);
    send_request(pcgbr_pkg::REQ_BND32, 64'd9, 64'd3);
    send_request(pcgbr_pkg::REQ_BND32, 64'h0, 64'hFFFF_FFFF);
    send_request(pcgbr_pkg::REQ_BND32, 64'hDEAD_BEEF_0000_0000, 64'h1234_5678_FFFF_FFFF);
    send_request(pcgbr_pkg::REQ_BND32, 64'hFFFF_FFFF_0000_0010, 64'h0000_0000_0000_0011);
    send_request(pcgbr_pkg::REQ_BND32, 64'd0, 64'd1);
    send_request(pcgbr_pkg::REQ_BND32, 64'hFFFF_FFFE, 64'hFFFF_FFFF);
    send_request(pcgbr_pkg::REQ_BND32, 64'h8000_0000, 64'hFFFF_FFFF);
    send_request(pcgbr_pkg::REQ_BND64, 64'd5, 64'd5);
    send_request(pcgbr_pkg::REQ_BND64, '1, '0);
    send_request(pcgbr_pkg::REQ_BND64, '0, '1);
    send_request(pcgbr_pkg::REQ_BND64, 64'd0, 64'd1);
    send_request(pcgbr_pkg::REQ_BND64, 64'hFFFF_FFFF_FFFF_FFFE, '1);
    send_request(pcgbr_pkg::REQ_BND64, 64'h0, 64'h8000_0000_0000_0000);
    send_request(pcgbr_pkg::REQ_BND64, 64'd100, 64'd1000);
    send_request(pcgbr_pkg::REQ_RAW64, '0, '0);
    send_request(pcgbr_pkg::REQ_RAW32, '1, '1);
    write_seed('1);
    send_request(pcgbr_pkg::REQ_RAW64, '0, '0);
    send_request(pcgbr_pkg::REQ_BND32, 64'd1, 64'd6);
  endtask

  task automatic test_backpressure();
    @(negedge clk_i);
    hold_off_cycles = 800;
    repeat (6) send_request(pcgbr_pkg::REQ_BND32, 64'd10, 64'd20);
    send_request(pcgbr_pkg::REQ_RAW32, '0, '0);
    drain();
  endtask

  task automatic random_bounds(pcgbr_pkg::req_type_e kind, output logic [63:0] lo,
                               output logic [63:0] hi);
    lo = {$urandom, $urandom};
    hi = {$urandom, $urandom};
    case ($urandom_range(0, 9))
      0, 1, 2, 3: hi = lo + $urandom_range(1, 1000);
      4:          hi = lo;
      5:          begin lo = '0; hi = '1; end
      6:          hi = lo + {32'd0, $urandom};
      7:          hi = (kind == pcgbr_pkg::REQ_BND32)
                       ? {hi[63:32], lo[31:0] + $urandom_range(1, 50)}
                       : lo + {$urandom, $urandom} / 2;
      default:    ;
    endcase
  endtask

  task automatic test_random();
    pcgbr_pkg::req_type_e kind;
    logic [63:0] lo, hi;
    for (int unsigned n = 0; n < RandomItems; n++) begin
      if (n % 400 == 399) write_seed({$urandom, $urandom});
      kind = pcgbr_pkg::req_type_e'($urandom_range(0, 3));
      random_bounds(kind, lo, hi);
      send_request(kind, lo, hi);
    end
  endtask

  initial begin
    rst_ni = 1'b0;
    seed_we_i = 1'b0;
    seed_value_i = '0;
    req_ch.valid = 1'b0;
    req_ch.req_type = pcgbr_pkg::REQ_RAW32;
    req_ch.range_low = '0;
    req_ch.range_high = '0;
    rsp_ch.ready = 1'b0;
    gen_state = pcgbr_pkg::PcgInc;
    repeat (2) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);
    test_reset_state();
    test_directed();
    test_backpressure();
    test_random();
    drain();
    repeat (200) @(negedge clk_i);
    if (mismatch_count == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

// File: filelist.f
rtl/core/pcgbr_pkg.sv
rtl/core/pcgbr_req_if.sv
rtl/core/pcgbr_serial_mul.sv
rtl/core/pcgbr_serial_div.sv
rtl/core/pcgbr_gen.sv
rtl/core/pcg_bounded_random_generator.sv
sim/tb.sv
